[design/eic_pkg.sv]
// Shared types and constants for the edge interrupt controller.
// No dependencies; compiled first.
package eic_pkg;

  // line counts
  localparam int EDGE_LINES    = 23;
  localparam int TOTAL_LINES   = 30;
  localparam int DIRECT_LINES  = TOTAL_LINES - EDGE_LINES;
  localparam int RESERVED_LINE = 18;
  localparam int LAST_EDGE     = 22;
  localparam int DATA_W        = 32;

  // item codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_INT_MASK   = 3'd0;
  localparam logic [2:0] REG_EVENT_MASK = 3'd1;
  localparam logic [2:0] REG_RISE       = 3'd2;
  localparam logic [2:0] REG_FALL       = 3'd3;
  localparam logic [2:0] REG_PENDING    = 3'd4;

  // implemented bits
  localparam logic [DATA_W-1:0] IMPL_MASK_RAW = 32'h37FF_FFFF;
  localparam logic [TOTAL_LINES-1:0] IMPL_MASK = IMPL_MASK_RAW[TOTAL_LINES-1:0];
  localparam logic [EDGE_LINES-1:0] EDGE_MASK =
    ~(EDGE_LINES'(1) << RESERVED_LINE);

  // gpio group masks over the low 16 lines
  localparam logic [15:0] GROUP_PAIR_LOW  = 16'h0003;
  localparam logic [15:0] GROUP_PAIR_HIGH = 16'h000C;
  localparam logic [15:0] GROUP_UPPER     = 16'hFFF0;

  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic [TOTAL_LINES-1:0] line_requests;
    logic                   group_low_pair;
    logic                   group_high_pair;
    logic                   group_upper_pins;
    logic [EDGE_LINES-1:0]  event_pulses;
    logic                   bad_access;
  } eic_result_t;

endpackage

[design/eic_if.sv]
// Valid/ready channel interfaces for the edge interrupt controller.
// Depends on eic_pkg for field widths.
interface eic_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [2:0]                      reg_index;
  logic [eic_pkg::DATA_W-1:0]      write_data;
  logic [eic_pkg::TOTAL_LINES-1:0] line_levels;

  modport source (output valid, output opcode, output reg_index, output write_data,
                  output line_levels, input ready);
  modport sink   (input valid, input opcode, input reg_index, input write_data,
                  input line_levels, output ready);
endinterface

interface eic_out_if;
  logic                            valid;
  logic                            ready;
  logic [eic_pkg::DATA_W-1:0]      read_data;
  logic [eic_pkg::TOTAL_LINES-1:0] line_requests;
  logic                            group_low_pair;
  logic                            group_high_pair;
  logic                            group_upper_pins;
  logic [eic_pkg::EDGE_LINES-1:0]  event_pulses;
  logic                            bad_access;

  modport source (output valid, output read_data, output line_requests,
                  output group_low_pair, output group_high_pair,
                  output group_upper_pins, output event_pulses,
                  output bad_access, input ready);
  modport sink   (input valid, input read_data, input line_requests,
                  input group_low_pair, input group_high_pair,
                  input group_upper_pins, input event_pulses,
                  input bad_access, output ready);
endinterface

[design/eic_regfile.sv]
// Register file, edge detection and request logic of the interrupt controller.
// Depends on eic_pkg; updates its state on each accepted beat.
module eic_regfile (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [1:0]                      opcode,
  input  logic [2:0]                      reg_index,
  input  logic [eic_pkg::DATA_W-1:0]      write_data,
  input  logic [eic_pkg::TOTAL_LINES-1:0] line_levels,
  output eic_pkg::eic_result_t            result
);
  import eic_pkg::*;

  logic [TOTAL_LINES-1:0] int_mask_r, int_mask_nxt;
  logic [TOTAL_LINES-1:0] event_mask_r, event_mask_nxt;
  logic [EDGE_LINES-1:0]  rise_r, rise_nxt;
  logic [EDGE_LINES-1:0]  fall_r, fall_nxt;
  logic [EDGE_LINES-1:0]  pending_r, pending_nxt;
  logic [TOTAL_LINES-1:0] prev_levels_r, prev_levels_nxt;

  logic [EDGE_LINES-1:0]  edge_levels;
  logic [EDGE_LINES-1:0]  edge_prev;
  logic [EDGE_LINES-1:0]  hits;
  logic                   idx_ok;
  logic [DATA_W-1:0]      rd_data;
  logic [EDGE_LINES-1:0]  events;
  logic [TOTAL_LINES-1:0] req;

  // selected edges on edge lines
  assign edge_levels = line_levels[EDGE_LINES-1:0];
  assign edge_prev   = prev_levels_r[EDGE_LINES-1:0];
  assign hits = ((edge_levels & ~edge_prev & rise_r) |
                 (~edge_levels & edge_prev & fall_r)) & EDGE_MASK;

  // index decode
  always_comb begin
    unique case (reg_index)
      REG_INT_MASK, REG_EVENT_MASK, REG_RISE, REG_FALL, REG_PENDING: idx_ok = 1'b1;
      default: idx_ok = 1'b0;
    endcase
  end

  // next state and read data
  always_comb begin
    int_mask_nxt    = int_mask_r;
    event_mask_nxt  = event_mask_r;
    rise_nxt        = rise_r;
    fall_nxt        = fall_r;
    pending_nxt     = pending_r;
    prev_levels_nxt = prev_levels_r;
    rd_data         = '0;
    events          = '0;
    unique case (opcode)
      OP_WRITE: begin
        unique case (reg_index)
          REG_INT_MASK:   int_mask_nxt   = write_data[TOTAL_LINES-1:0] & IMPL_MASK;
          REG_EVENT_MASK: event_mask_nxt = write_data[TOTAL_LINES-1:0] & IMPL_MASK;
          REG_RISE:       rise_nxt       = write_data[EDGE_LINES-1:0] & EDGE_MASK;
          REG_FALL:       fall_nxt       = write_data[EDGE_LINES-1:0] & EDGE_MASK;
          REG_PENDING:    pending_nxt    = pending_r & ~write_data[EDGE_LINES-1:0];
          default: ;
        endcase
      end
      OP_READ: begin
        unique case (reg_index)
          REG_INT_MASK:   rd_data = DATA_W'(int_mask_r);
          REG_EVENT_MASK: rd_data = DATA_W'(event_mask_r);
          REG_RISE:       rd_data = DATA_W'(rise_r);
          REG_FALL:       rd_data = DATA_W'(fall_r);
          REG_PENDING:    rd_data = DATA_W'(pending_r);
          default: ;
        endcase
      end
      OP_TICK: begin
        pending_nxt     = (pending_r | hits) & EDGE_MASK;
        events          = hits & event_mask_r[EDGE_LINES-1:0];
        prev_levels_nxt = line_levels;
      end
      default: ;
    endcase
  end

  // requests from the updated state
  assign req = {prev_levels_nxt[TOTAL_LINES-1:EDGE_LINES] &
                int_mask_nxt[TOTAL_LINES-1:EDGE_LINES],
                pending_nxt & int_mask_nxt[EDGE_LINES-1:0]};

  always_comb begin
    result.read_data        = rd_data;
    result.line_requests    = req;
    result.group_low_pair   = |(req[15:0] & GROUP_PAIR_LOW);
    result.group_high_pair  = |(req[15:0] & GROUP_PAIR_HIGH);
    result.group_upper_pins = |(req[15:0] & GROUP_UPPER);
    result.event_pulses     = events;
    result.bad_access       = ((opcode == OP_WRITE) || (opcode == OP_READ)) && !idx_ok;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_mask_r    <= '0;
      event_mask_r  <= '0;
      rise_r        <= '0;
      fall_r        <= '0;
      pending_r     <= '0;
      prev_levels_r <= '0;
    end else if (accept) begin
      int_mask_r    <= int_mask_nxt;
      event_mask_r  <= event_mask_nxt;
      rise_r        <= rise_nxt;
      fall_r        <= fall_nxt;
      pending_r     <= pending_nxt;
      prev_levels_r <= prev_levels_nxt;
    end
  end

endmodule

[design/edge_interrupt_controller_core.sv]
// A result goes to the output register, or to the skid register while the output stalls.
// Throughput: one beat per cycle while the skid register is empty.
// A two-entry output buffer (output register plus skid register) keeps input ready
// registered, so one input beat is still taken while a result waits.
// Reset (synchronous, rst_n low) clears the controller state and both buffer valid flags;
// the buffer payload registers are not reset. Depends on eic_pkg, eic_if and eic_regfile.
module edge_interrupt_controller_core (
  input  logic clk,
  input  logic rst_n,
  eic_in_if.sink    in_ch,
  eic_out_if.source out_ch
);
  import eic_pkg::*;

  logic        accept;
  logic        in_ready;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  eic_result_t res;
  eic_result_t out_data_r, out_data_nxt;
  eic_result_t skid_data_r, skid_data_nxt;

  assign in_ready    = !skid_valid_r;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  eic_regfile u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .opcode      (in_ch.opcode),
    .reg_index   (in_ch.reg_index),
    .write_data  (in_ch.write_data),
    .line_levels (in_ch.line_levels),
    .result      (res)
  );

  // output buffer steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_ch.ready) begin
      if (accept) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = accept;
      if (accept) begin
        out_data_nxt = res;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.read_data        = out_data_r.read_data;
  assign out_ch.line_requests    = out_data_r.line_requests;
  assign out_ch.group_low_pair   = out_data_r.group_low_pair;
  assign out_ch.group_high_pair  = out_data_r.group_high_pair;
  assign out_ch.group_upper_pins = out_data_r.group_upper_pins;
  assign out_ch.event_pulses     = out_data_r.event_pulses;
  assign out_ch.bad_access       = out_data_r.bad_access;

endmodule

[design/eic_checker.sv]
// Port-level checks for the edge interrupt controller, bound to the top level.
// Depends on eic_pkg and edge_interrupt_controller_core.
module eic_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [eic_pkg::DATA_W-1:0]      read_data,
  input logic [eic_pkg::TOTAL_LINES-1:0] line_requests,
  input logic                            group_low_pair,
  input logic                            group_upper_pins,
  input logic [eic_pkg::EDGE_LINES-1:0]  event_pulses,
  input logic                            bad_access
);
  import eic_pkg::*;

  // a result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a rejected access never returns data
  a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_access |-> read_data == '0)
    else $error("bad access returned read data");

  // low-pair and upper-pin group requests follow the per-line requests
  a_groups: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (group_low_pair == (|line_requests[1:0])) &&
                  (group_upper_pins == (|line_requests[15:4])))
    else $error("group request mismatch");

  // unimplemented lines never request or pulse
  a_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !line_requests[RESERVED_LINE] && !event_pulses[RESERVED_LINE] &&
                  !line_requests[27])
    else $error("request on unimplemented line");

endmodule

bind edge_interrupt_controller_core eic_checker u_eic_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .read_data        (out_ch.read_data),
  .line_requests    (out_ch.line_requests),
  .group_low_pair   (out_ch.group_low_pair),
  .group_upper_pins (out_ch.group_upper_pins),
  .event_pulses     (out_ch.event_pulses),
  .bad_access       (out_ch.bad_access)
);
